FILE: src/bkrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot keyboard report decoder package
// Word types, report constants and code values shared by the decoder files.
// ----------------------------------------------------------------------------
package bkrd_pkg;

  localparam int MAX_KEYS   = 6;
  localparam int IN_SLOTS   = 6;
  localparam int USED_SLOTS = (MAX_KEYS < IN_SLOTS) ? MAX_KEYS : IN_SLOTS;
  localparam int CNT_W      = $clog2(IN_SLOTS + 1);

  localparam logic [7:0] REPORT_LEN      = 8'(MAX_KEYS + 2);
  localparam logic [7:0] LEN_DISCONNECT  = 8'h00;
  localparam logic [7:0] USAGE_NONE      = 8'h00;
  localparam logic [7:0] USAGE_ERR_LO    = 8'h01;
  localparam logic [7:0] USAGE_ERR_HI    = 8'h03;
  localparam logic [7:0] USAGE_NUM_LOCK  = 8'h53;
  localparam logic [7:0] USAGE_CAPS_LOCK = 8'h39;
  localparam logic [7:0] SHIFT_MASK      = 8'h22;

  localparam int LED_NUM_BIT  = 0;
  localparam int LED_CAPS_BIT = 1;

  localparam logic EVT_KEY        = 1'b0;
  localparam logic EVT_DISCONNECT = 1'b1;

  typedef struct packed {
    logic [7:0] report_len;
    logic [7:0] modifiers;
    logic [7:0] key_0;
    logic [7:0] key_1;
    logic [7:0] key_2;
    logic [7:0] key_3;
    logic [7:0] key_4;
    logic [7:0] key_5;
  } in_word_t;

  typedef struct packed {
    logic       event_kind;
    logic [7:0] modifier_bits;
    logic [7:0] new_scan_code;
    logic [7:0] ascii_char;
    logic       led_send;
    logic [1:0] led_bits;
  } out_word_t;

endpackage

FILE: src/bkrd_keymap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot keyboard key map
// Two-level ROM: usage code to key position, key position to character.
// ----------------------------------------------------------------------------
module bkrd_keymap (
  input  logic [7:0] usage,
  input  logic       upper,
  output logic [7:0] ascii_char
);

  localparam logic [7:0] LOW_POS [104] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd31,  8'd50,  8'd48,  8'd33,
    8'd19,  8'd34,  8'd35,  8'd36,  8'd24,  8'd37,  8'd38,  8'd39,
    8'd52,  8'd51,  8'd25,  8'd26,  8'd17,  8'd20,  8'd32,  8'd21,
    8'd23,  8'd49,  8'd18,  8'd47,  8'd22,  8'd46,  8'd2,   8'd3,
    8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,
    8'd43,  8'd110, 8'd15,  8'd16,  8'd61,  8'd12,  8'd13,  8'd27,
    8'd28,  8'd29,  8'd42,  8'd40,  8'd41,  8'd1,   8'd53,  8'd54,
    8'd55,  8'd30,  8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117,
    8'd118, 8'd119, 8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd125,
    8'd126, 8'd75,  8'd80,  8'd85,  8'd76,  8'd81,  8'd86,  8'd89,
    8'd79,  8'd84,  8'd83,  8'd90,  8'd95,  8'd100, 8'd105, 8'd106,
    8'd108, 8'd93,  8'd98,  8'd103, 8'd92,  8'd97,  8'd102, 8'd91,
    8'd96,  8'd101, 8'd99,  8'd104, 8'd45,  8'd129, 8'd0,   8'd0
  };

  localparam logic [7:0] MOD_POS [8] = '{
    8'd58, 8'd44, 8'd60, 8'd127, 8'd64, 8'd57, 8'd62, 8'd128
  };

  function automatic logic [7:0] key_pos(input logic [7:0] u);
    logic [7:0] p;
    p = 8'd0;
    if (u < 8'h68) begin
      p = LOW_POS[u[6:0]];
    end else if (u == 8'h85) begin
      p = 8'd107;
    end else if (u == 8'h87) begin
      p = 8'd56;
    end else if (u inside {[8'hE0:8'hE7]}) begin
      p = MOD_POS[u[2:0]];
    end
    return p;
  endfunction

  function automatic logic [7:0] plain_char(input logic [7:0] p);
    logic [7:0] c;
    case (p)
      8'd1:    c = 8'h60;
      8'd2:    c = 8'h31;
      8'd3:    c = 8'h32;
      8'd4:    c = 8'h33;
      8'd5:    c = 8'h34;
      8'd6:    c = 8'h35;
      8'd7:    c = 8'h36;
      8'd8:    c = 8'h37;
      8'd9:    c = 8'h38;
      8'd10:   c = 8'h39;
      8'd11:   c = 8'h30;
      8'd12:   c = 8'h2D;
      8'd13:   c = 8'h3D;
      8'd15:   c = 8'h08;
      8'd16:   c = 8'h09;
      8'd17:   c = 8'h71;
      8'd18:   c = 8'h77;
      8'd19:   c = 8'h65;
      8'd20:   c = 8'h72;
      8'd21:   c = 8'h74;
      8'd22:   c = 8'h79;
      8'd23:   c = 8'h75;
      8'd24:   c = 8'h69;
      8'd25:   c = 8'h6F;
      8'd26:   c = 8'h70;
      8'd27:   c = 8'h5B;
      8'd28:   c = 8'h5D;
      8'd29:   c = 8'h5C;
      8'd31:   c = 8'h61;
      8'd32:   c = 8'h73;
      8'd33:   c = 8'h64;
      8'd34:   c = 8'h66;
      8'd35:   c = 8'h67;
      8'd36:   c = 8'h68;
      8'd37:   c = 8'h6A;
      8'd38:   c = 8'h6B;
      8'd39:   c = 8'h6C;
      8'd40:   c = 8'h3B;
      8'd41:   c = 8'h27;
      8'd43:   c = 8'h0A;
      8'd46:   c = 8'h7A;
      8'd47:   c = 8'h78;
      8'd48:   c = 8'h63;
      8'd49:   c = 8'h76;
      8'd50:   c = 8'h62;
      8'd51:   c = 8'h6E;
      8'd52:   c = 8'h6D;
      8'd53:   c = 8'h2C;
      8'd54:   c = 8'h2E;
      8'd55:   c = 8'h2F;
      8'd61:   c = 8'h20;
      8'd80:   c = 8'h0D;
      8'd91:   c = 8'h37;
      8'd92:   c = 8'h34;
      8'd93:   c = 8'h31;
      8'd95:   c = 8'h2F;
      8'd96:   c = 8'h38;
      8'd97:   c = 8'h35;
      8'd98:   c = 8'h32;
      8'd99:   c = 8'h30;
      8'd100:  c = 8'h2A;
      8'd101:  c = 8'h39;
      8'd102:  c = 8'h36;
      8'd103:  c = 8'h33;
      8'd104:  c = 8'h2E;
      8'd105:  c = 8'h2D;
      8'd106:  c = 8'h2B;
      8'd108:  c = 8'h0A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] shift_char(input logic [7:0] p);
    logic [7:0] c;
    case (p)
      8'd1:    c = 8'h7E;
      8'd2:    c = 8'h21;
      8'd3:    c = 8'h40;
      8'd4:    c = 8'h23;
      8'd5:    c = 8'h24;
      8'd6:    c = 8'h25;
      8'd7:    c = 8'h5E;
      8'd8:    c = 8'h26;
      8'd9:    c = 8'h2A;
      8'd10:   c = 8'h28;
      8'd11:   c = 8'h29;
      8'd12:   c = 8'h5F;
      8'd13:   c = 8'h2B;
      8'd15:   c = 8'h08;
      8'd17:   c = 8'h51;
      8'd18:   c = 8'h57;
      8'd19:   c = 8'h45;
      8'd20:   c = 8'h52;
      8'd21:   c = 8'h54;
      8'd22:   c = 8'h59;
      8'd23:   c = 8'h55;
      8'd24:   c = 8'h49;
      8'd25:   c = 8'h4F;
      8'd26:   c = 8'h50;
      8'd27:   c = 8'h7B;
      8'd28:   c = 8'h7D;
      8'd29:   c = 8'h7C;
      8'd31:   c = 8'h41;
      8'd32:   c = 8'h53;
      8'd33:   c = 8'h44;
      8'd34:   c = 8'h46;
      8'd35:   c = 8'h47;
      8'd36:   c = 8'h48;
      8'd37:   c = 8'h4A;
      8'd38:   c = 8'h4B;
      8'd39:   c = 8'h4C;
      8'd40:   c = 8'h3A;
      8'd41:   c = 8'h22;
      8'd43:   c = 8'h0A;
      8'd46:   c = 8'h5A;
      8'd47:   c = 8'h58;
      8'd48:   c = 8'h43;
      8'd49:   c = 8'h56;
      8'd50:   c = 8'h42;
      8'd51:   c = 8'h4E;
      8'd52:   c = 8'h4D;
      8'd53:   c = 8'h3C;
      8'd54:   c = 8'h3E;
      8'd55:   c = 8'h3F;
      8'd61:   c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  logic [7:0] pos;

  assign pos        = key_pos(usage);
  assign ascii_char = upper ? shift_char(pos) : plain_char(pos);

endmodule

FILE: src/boot_keyboard_report_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot keyboard report decoder
// Decodes boot-protocol keyboard reports into key events and LED requests.
//
// in_valid/in_ready carry one report word: byte count, modifier byte and six
// usage codes. out_valid/out_ready carry one event word. A byte count of zero
// gives a disconnect event and clears all key and LED state. A report whose
// byte count is not the full boot length, or that carries an error usage
// (codes 1 to 3), is dropped with no event and no state change.
// A word passes through the input register, then the decode result lands in the
// output register. Throughput is one word per cycle while the receiver does not
// stall; key and LED state update in the same cycle as the decode, so
// back-to-back reports see each other's state.
// While the receiver stalls the output word holds; the input register still
// drains words that give no event, and in_ready drops only when a word that
// gives an event waits behind a full output register.
// Reset (rst_n low, synchronous) empties both registers and clears state.
// ----------------------------------------------------------------------------
module boot_keyboard_report_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bkrd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bkrd_pkg::out_word_t out_data
);

  localparam int NS = bkrd_pkg::IN_SLOTS;
  localparam int CW = bkrd_pkg::CNT_W;

  logic                s1_v_r;
  bkrd_pkg::in_word_t  s1_data_r;
  logic                out_v_r;
  bkrd_pkg::out_word_t out_data_r;

  logic [7:0]    prev_keys_r [NS];
  logic [CW-1:0] prev_cnt_r;
  logic          num_held_r;
  logic          caps_held_r;
  logic [1:0]    led_r;
  logic [1:0]    led_sent_r;

  logic [7:0]    slot [NS];
  logic [NS-1:0] nz;
  logic [NS-1:0] fresh;
  logic [CW-1:0] cur_cnt;
  logic [7:0]    first_new;
  logic          is_disc;
  logic          len_ok;
  logic          has_err;
  logic          produce;
  logic          s1_go;
  logic          num_now;
  logic          caps_now;
  logic          one_new;
  logic          upper;
  logic [1:0]    led_nxt;
  logic [7:0]    new_key;
  logic [7:0]    map_char;
  bkrd_pkg::out_word_t res;

  always_comb begin
    slot[0] = s1_data_r.key_0;
    slot[1] = s1_data_r.key_1;
    slot[2] = s1_data_r.key_2;
    slot[3] = s1_data_r.key_3;
    slot[4] = s1_data_r.key_4;
    slot[5] = s1_data_r.key_5;
    for (int i = 0; i < NS; i++) begin
      if (i >= bkrd_pkg::USED_SLOTS) begin
        slot[i] = bkrd_pkg::USAGE_NONE;
      end
    end
  end

  always_comb begin
    logic seen;
    has_err   = 1'b0;
    num_now   = 1'b0;
    caps_now  = 1'b0;
    cur_cnt   = '0;
    first_new = bkrd_pkg::USAGE_NONE;
    for (int i = 0; i < NS; i++) begin
      if (slot[i] inside {[bkrd_pkg::USAGE_ERR_LO:bkrd_pkg::USAGE_ERR_HI]}) begin
        has_err = 1'b1;
      end
      if (slot[i] == bkrd_pkg::USAGE_NUM_LOCK) begin
        num_now = 1'b1;
      end
      if (slot[i] == bkrd_pkg::USAGE_CAPS_LOCK) begin
        caps_now = 1'b1;
      end
      nz[i] = (slot[i] != bkrd_pkg::USAGE_NONE);
      cur_cnt = cur_cnt + CW'(nz[i]);
      seen = 1'b0;
      for (int j = 0; j < NS; j++) begin
        if (prev_keys_r[j] == slot[i]) begin
          seen = 1'b1;
        end
      end
      fresh[i] = nz[i] && !(seen && (prev_cnt_r != '0));
    end
    for (int i = NS - 1; i >= 0; i--) begin
      if (fresh[i]) begin
        first_new = slot[i];
      end
    end
  end

  assign is_disc = (s1_data_r.report_len == bkrd_pkg::LEN_DISCONNECT);
  assign len_ok  = (s1_data_r.report_len == bkrd_pkg::REPORT_LEN);
  assign produce = is_disc || (len_ok && !has_err);
  assign s1_go   = s1_v_r && (!produce || !out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_go;

  assign one_new = $onehot(fresh);
  assign new_key = one_new ? first_new : bkrd_pkg::USAGE_NONE;

  always_comb begin
    led_nxt = led_r;
    led_nxt[bkrd_pkg::LED_NUM_BIT]  = led_r[bkrd_pkg::LED_NUM_BIT] ^ (num_now && !num_held_r);
    led_nxt[bkrd_pkg::LED_CAPS_BIT] = led_r[bkrd_pkg::LED_CAPS_BIT]
                                      ^ (caps_now && !caps_held_r);
  end

  assign upper = (|(s1_data_r.modifiers & bkrd_pkg::SHIFT_MASK))
                 ^ led_nxt[bkrd_pkg::LED_CAPS_BIT];

  bkrd_keymap u_keymap (
    .usage      (new_key),
    .upper      (upper),
    .ascii_char (map_char)
  );

  always_comb begin
    res = '0;
    if (is_disc) begin
      res.event_kind = bkrd_pkg::EVT_DISCONNECT;
    end else begin
      res.event_kind    = bkrd_pkg::EVT_KEY;
      res.modifier_bits = s1_data_r.modifiers;
      res.new_scan_code = new_key;
      res.ascii_char    = one_new ? map_char : 8'h00;
      res.led_send      = (led_nxt != led_sent_r);
      res.led_bits      = led_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go && produce) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && produce) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cnt_r  <= '0;
      num_held_r  <= 1'b0;
      caps_held_r <= 1'b0;
      led_r       <= 2'b00;
      led_sent_r  <= 2'b00;
    end else if (s1_go && is_disc) begin
      prev_cnt_r  <= '0;
      num_held_r  <= 1'b0;
      caps_held_r <= 1'b0;
      led_r       <= 2'b00;
      led_sent_r  <= 2'b00;
    end else if (s1_go && produce) begin
      prev_cnt_r  <= cur_cnt;
      num_held_r  <= num_now;
      caps_held_r <= caps_now;
      led_r       <= led_nxt;
      led_sent_r  <= led_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && produce && !is_disc) begin
      for (int i = 0; i < NS; i++) begin
        prev_keys_r[i] <= slot[i];
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/bkrd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot keyboard report decoder checker
// Port-level assertions on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bkrd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bkrd_pkg::out_word_t out_data
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output word changed or dropped");

  a_disc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind == bkrd_pkg::EVT_DISCONNECT) |->
      (out_data.modifier_bits == 8'h00) && (out_data.new_scan_code == 8'h00) &&
      (out_data.ascii_char == 8'h00) && !out_data.led_send &&
      (out_data.led_bits == 2'b00))
    else $error("disconnect word carries key or LED data");

  a_char_has_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.ascii_char != 8'h00) |->
      (out_data.new_scan_code != 8'h00))
    else $error("character without a new key");

  a_no_input_no_output: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) && !$past(in_valid && in_ready) |=>
      !out_valid)
    else $error("output word appeared with no word in flight");

endmodule

bind boot_keyboard_report_decoder_top bkrd_checker u_bkrd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot keyboard report decoder testbench
// Drives boot keyboard reports through the valid/ready input channel and
// checks every event word against a key, lock and LED state predictor kept
// alongside. A short table of hand-picked reports comes first, then random
// typing sequences mixed with malformed, error and disconnect reports. Both
// sides idle at random; a watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int MAX_SHOWN      = 100;

  localparam logic [7:0] LOW_POS [104] = '{
    0, 0, 0, 0, 31, 50, 48, 33, 19, 34, 35, 36, 24, 37, 38, 39,
    52, 51, 25, 26, 17, 20, 32, 21, 23, 49, 18, 47, 22, 46, 2, 3,
    4, 5, 6, 7, 8, 9, 10, 11, 43, 110, 15, 16, 61, 12, 13, 27,
    28, 29, 42, 40, 41, 1, 53, 54, 55, 30, 112, 113, 114, 115, 116, 117,
    118, 119, 120, 121, 122, 123, 124, 125, 126, 75, 80, 85, 76, 81, 86, 89,
    79, 84, 83, 90, 95, 100, 105, 106, 108, 93, 98, 103, 92, 97, 102, 91,
    96, 101, 99, 104, 45, 129, 0, 0
  };

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_CHOKE} rx_mode_t;

  typedef struct {
    bkrd_pkg::in_word_t  word;
    bit                  fixed;
    bit                  fixed_has;
    bkrd_pkg::out_word_t fixed_ev;
  } report_row_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  bkrd_pkg::in_word_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  bkrd_pkg::out_word_t out_data;

  report_row_t         dir_q[$];
  report_row_t         sent_q[$];
  bkrd_pkg::out_word_t event_q[$];
  int                  errors      = 0;
  int                  idle_cycles = 0;
  int                  burst_left  = 0;

  logic [7:0] held_keys [bkrd_pkg::IN_SLOTS];
  int         held_n;
  logic       num_held;
  logic       caps_held;
  logic [1:0] led_now;
  logic [1:0] led_sent;

  logic [7:0] down_q[$];
  logic [7:0] gen_mods = 8'h00;

  rx_mode_t    rx_mode    = RX_OPEN;
  int          rx_left    = 0;
  logic [15:0] rx_pattern = 16'h1;
  logic [3:0]  rx_phase   = 4'd0;

  report_row_t         mon_row;
  bkrd_pkg::out_word_t mon_ev;
  bit                  mon_has;

  boot_keyboard_report_decoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] usage_pos(input logic [7:0] u);
    if (u < 8'h68) return LOW_POS[u[6:0]];
    case (u)
      8'h85: return 8'd107;
      8'h87: return 8'd56;
      8'he0: return 8'd58;
      8'he1: return 8'd44;
      8'he2: return 8'd60;
      8'he3: return 8'd127;
      8'he4: return 8'd64;
      8'he5: return 8'd57;
      8'he6: return 8'd62;
      8'he7: return 8'd128;
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] key_char(input logic [7:0] pos, input logic upper);
    if (upper) begin
      case (pos)
        8'd1: return "~";   8'd2: return "!";   8'd3: return "@";   8'd4: return "#";
        8'd5: return "$";   8'd6: return "%";   8'd7: return "^";   8'd8: return "&";
        8'd9: return "*";   8'd10: return "(";  8'd11: return ")";  8'd12: return "_";
        8'd13: return "+";  8'd15: return 8'h08;
        8'd17: return "Q";  8'd18: return "W";  8'd19: return "E";  8'd20: return "R";
        8'd21: return "T";  8'd22: return "Y";  8'd23: return "U";  8'd24: return "I";
        8'd25: return "O";  8'd26: return "P";  8'd27: return "{";  8'd28: return "}";
        8'd29: return "|";  8'd31: return "A";  8'd32: return "S";  8'd33: return "D";
        8'd34: return "F";  8'd35: return "G";  8'd36: return "H";  8'd37: return "J";
        8'd38: return "K";  8'd39: return "L";  8'd40: return ":";  8'd41: return 8'h22;
        8'd43: return 8'h0a; 8'd46: return "Z"; 8'd47: return "X";  8'd48: return "C";
        8'd49: return "V";  8'd50: return "B";  8'd51: return "N";  8'd52: return "M";
        8'd53: return "<";  8'd54: return ">";  8'd55: return "?";  8'd61: return " ";
        default: return 8'h00;
      endcase
    end else begin
      case (pos)
        8'd1: return 8'h60; 8'd2: return "1";   8'd3: return "2";   8'd4: return "3";
        8'd5: return "4";   8'd6: return "5";   8'd7: return "6";   8'd8: return "7";
        8'd9: return "8";   8'd10: return "9";  8'd11: return "0";  8'd12: return "-";
        8'd13: return "=";  8'd15: return 8'h08; 8'd16: return 8'h09;
        8'd17: return "q";  8'd18: return "w";  8'd19: return "e";  8'd20: return "r";
        8'd21: return "t";  8'd22: return "y";  8'd23: return "u";  8'd24: return "i";
        8'd25: return "o";  8'd26: return "p";  8'd27: return "[";  8'd28: return "]";
        8'd29: return 8'h5c; 8'd31: return "a"; 8'd32: return "s";  8'd33: return "d";
        8'd34: return "f";  8'd35: return "g";  8'd36: return "h";  8'd37: return "j";
        8'd38: return "k";  8'd39: return "l";  8'd40: return ";";  8'd41: return 8'h27;
        8'd43: return 8'h0a; 8'd46: return "z"; 8'd47: return "x";  8'd48: return "c";
        8'd49: return "v";  8'd50: return "b";  8'd51: return "n";  8'd52: return "m";
        8'd53: return ",";  8'd54: return ".";  8'd55: return "/";  8'd61: return " ";
        8'd80: return 8'h0d; 8'd91: return "7"; 8'd92: return "4";  8'd93: return "1";
        8'd95: return "/";  8'd96: return "8";  8'd97: return "5";  8'd98: return "2";
        8'd99: return "0";  8'd100: return "*"; 8'd101: return "9"; 8'd102: return "6";
        8'd103: return "3"; 8'd104: return "."; 8'd105: return "-"; 8'd106: return "+";
        8'd108: return 8'h0a;
        default: return 8'h00;
      endcase
    end
  endfunction

  function automatic void clear_keys();
    held_keys = '{default: bkrd_pkg::USAGE_NONE};
    held_n    = 0;
    num_held  = 1'b0;
    caps_held = 1'b0;
    led_now   = 2'b00;
    led_sent  = 2'b00;
  endfunction

  function automatic bit decode_report(input bkrd_pkg::in_word_t w,
                                       output bkrd_pkg::out_word_t ev);
    logic [7:0] raw  [bkrd_pkg::IN_SLOTS];
    logic [7:0] slot [bkrd_pkg::IN_SLOTS];
    logic [7:0] cur  [bkrd_pkg::IN_SLOTS];
    logic [7:0] new_key;
    int         cur_n;
    int         new_n;
    logic       num_now;
    logic       caps_now;
    logic       seen;
    logic       upper;
    ev       = '0;
    cur      = '{default: bkrd_pkg::USAGE_NONE};
    new_key  = bkrd_pkg::USAGE_NONE;
    cur_n    = 0;
    new_n    = 0;
    num_now  = 1'b0;
    caps_now = 1'b0;
    raw = '{w.key_0, w.key_1, w.key_2, w.key_3, w.key_4, w.key_5};
    foreach (slot[i]) slot[i] = (i < bkrd_pkg::USED_SLOTS) ? raw[i] : bkrd_pkg::USAGE_NONE;
    if (w.report_len == bkrd_pkg::LEN_DISCONNECT) begin
      clear_keys();
      ev.event_kind = bkrd_pkg::EVT_DISCONNECT;
      return 1'b1;
    end
    if (w.report_len != bkrd_pkg::REPORT_LEN) return 1'b0;
    foreach (slot[i]) begin
      if (slot[i] >= bkrd_pkg::USAGE_ERR_LO && slot[i] <= bkrd_pkg::USAGE_ERR_HI)
        return 1'b0;
    end
    foreach (slot[i]) begin
      if (slot[i] == bkrd_pkg::USAGE_NUM_LOCK) num_now = 1'b1;
      if (slot[i] == bkrd_pkg::USAGE_CAPS_LOCK) caps_now = 1'b1;
      if (slot[i] != bkrd_pkg::USAGE_NONE) begin
        seen = 1'b0;
        for (int j = 0; j < held_n; j++) begin
          if (held_keys[j] == slot[i]) seen = 1'b1;
        end
        cur[cur_n] = slot[i];
        cur_n++;
        if (!seen) begin
          if (new_n == 0) new_key = slot[i];
          new_n++;
        end
      end
    end
    if (!num_held && num_now)
      led_now[bkrd_pkg::LED_NUM_BIT] = !led_now[bkrd_pkg::LED_NUM_BIT];
    if (!caps_held && caps_now)
      led_now[bkrd_pkg::LED_CAPS_BIT] = !led_now[bkrd_pkg::LED_CAPS_BIT];
    num_held    = num_now;
    caps_held   = caps_now;
    ev.led_send = (led_now != led_sent);
    led_sent    = led_now;
    if (new_n == 1) begin
      upper = ((w.modifiers & bkrd_pkg::SHIFT_MASK) != 8'h00)
              ^ led_now[bkrd_pkg::LED_CAPS_BIT];
      ev.new_scan_code = new_key;
      ev.ascii_char    = key_char(usage_pos(new_key), upper);
    end
    held_keys        = cur;
    held_n           = cur_n;
    ev.event_kind    = bkrd_pkg::EVT_KEY;
    ev.modifier_bits = w.modifiers;
    ev.led_bits      = led_now;
    return 1'b1;
  endfunction

  function automatic bkrd_pkg::in_word_t mk_report(input logic [7:0] len,
                                                   input logic [7:0] mods,
                                                   input logic [7:0] k0 = 0,
                                                   input logic [7:0] k1 = 0,
                                                   input logic [7:0] k2 = 0,
                                                   input logic [7:0] k3 = 0,
                                                   input logic [7:0] k4 = 0,
                                                   input logic [7:0] k5 = 0);
    return '{len, mods, k0, k1, k2, k3, k4, k5};
  endfunction

  function automatic bkrd_pkg::out_word_t mk_event(input logic kind, input logic [7:0] mods,
                                                   input logic [7:0] code,
                                                   input logic [7:0] ch,
                                                   input logic send,
                                                   input logic [1:0] leds);
    return '{kind, mods, code, ch, send, leds};
  endfunction

  function automatic void add_row(input bkrd_pkg::in_word_t w, input bit fixed = 1'b0,
                                  input bit fhas = 1'b0,
                                  input bkrd_pkg::out_word_t fev = '0);
    dir_q.push_back('{w, fixed, fhas, fev});
  endfunction

  function automatic logic [7:0] fresh_usage();
    logic [7:0] u;
    bit         dup;
    do begin
      case ($urandom_range(0, 9))
        0: u = bkrd_pkg::USAGE_CAPS_LOCK;
        1: u = bkrd_pkg::USAGE_NUM_LOCK;
        2: u = $urandom_range(0, 1) ? 8'(8'he0 + $urandom_range(0, 7))
                                    : ($urandom_range(0, 1) ? 8'h85 : 8'h87);
        3: u = 8'($urandom_range(4, 255));
        default: u = 8'($urandom_range(4, 8'h67));
      endcase
      dup = 1'b0;
      foreach (down_q[i]) begin
        if (down_q[i] == u) dup = 1'b1;
      end
    end while (dup);
    return u;
  endfunction

  function automatic bkrd_pkg::in_word_t pack_down();
    logic [7:0] s [bkrd_pkg::IN_SLOTS];
    int         p;
    s = '{default: bkrd_pkg::USAGE_NONE};
    foreach (down_q[i]) begin
      do p = $urandom_range(0, bkrd_pkg::IN_SLOTS - 1);
      while (s[p] != bkrd_pkg::USAGE_NONE);
      s[p] = down_q[i];
    end
    return mk_report(bkrd_pkg::REPORT_LEN, gen_mods, s[0], s[1], s[2], s[3], s[4], s[5]);
  endfunction

  function automatic report_row_t random_row();
    report_row_t row;
    int          pick;
    int          k;
    row.fixed     = 1'b0;
    row.fixed_has = 1'b0;
    row.fixed_ev  = '0;
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: if (down_q.size() < bkrd_pkg::IN_SLOTS) down_q.push_back(fresh_usage());
        4, 5, 6: if (down_q.size() != 0) down_q.delete($urandom_range(0, down_q.size() - 1));
        7: case ($urandom_range(0, 3))
             0: gen_mods = 8'($urandom);
             1: gen_mods = 8'h02;
             2: gen_mods = 8'h20;
             default: gen_mods = 8'h00;
           endcase
        8: down_q.delete();
        default: ;
      endcase
      row.word = pack_down();
    end else if (pick < 86) begin
      row.word = bkrd_pkg::in_word_t'({$urandom, $urandom});
      if ($urandom_range(0, 1)) row.word.report_len = bkrd_pkg::REPORT_LEN;
    end else if (pick < 92) begin
      row.word = bkrd_pkg::in_word_t'({$urandom, $urandom});
      while (row.word.report_len == bkrd_pkg::REPORT_LEN ||
             row.word.report_len == bkrd_pkg::LEN_DISCONNECT)
        row.word.report_len = 8'($urandom);
    end else if (pick < 97) begin
      row.word = pack_down();
      k = $urandom_range(0, bkrd_pkg::IN_SLOTS - 1);
      row.word[8*k +: 8] = 8'($urandom_range(bkrd_pkg::USAGE_ERR_LO, bkrd_pkg::USAGE_ERR_HI));
    end else begin
      row.word = bkrd_pkg::in_word_t'({$urandom, $urandom});
      row.word.report_len = bkrd_pkg::LEN_DISCONNECT;
      down_q.delete();
    end
    return row;
  endfunction

  function automatic void check_field(input string what, input logic [7:0] expv,
                                      input logic [7:0] actv);
    if (expv !== actv) begin
      errors++;
      if (errors <= MAX_SHOWN)
        $display("%0t: %s expected %0h got %0h", $time, what, expv, actv);
    end
  endfunction

  task automatic send_row(input report_row_t row);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    burst_left--;
    sent_q.push_back(row);
    in_valid <= 1'b1;
    in_data  <= row.word;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (event_q.size() != 0) @(posedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode    <= rx_mode_t'($urandom_range(0, 3));
      rx_left    <= $urandom_range(16, 256);
      rx_pattern <= 16'($urandom) | 16'h1;
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_phase <= rx_phase + 4'd1;
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
      RX_PATTERN: out_ready <= rx_pattern[rx_phase];
      default:    out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (event_q.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: event word expected none got %h", $time, out_data);
        end else begin
          mon_ev = event_q.pop_front();
          check_field("event_kind", 8'(mon_ev.event_kind), 8'(out_data.event_kind));
          check_field("modifier_bits", mon_ev.modifier_bits, out_data.modifier_bits);
          check_field("new_scan_code", mon_ev.new_scan_code, out_data.new_scan_code);
          check_field("ascii_char", mon_ev.ascii_char, out_data.ascii_char);
          check_field("led_send", 8'(mon_ev.led_send), 8'(out_data.led_send));
          check_field("led_bits", 8'(mon_ev.led_bits), 8'(out_data.led_bits));
        end
      end
      if (in_valid && in_ready) begin
        mon_row = sent_q.pop_front();
        mon_has = decode_report(mon_row.word, mon_ev);
        if (mon_row.fixed) begin
          mon_has = mon_row.fixed_has;
          mon_ev  = mon_row.fixed_ev;
        end
        if (mon_has) begin
          event_q.push_back(mon_ev);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_keys();
    add_row(mk_report(bkrd_pkg::LEN_DISCONNECT, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                      8'hff),
            1'b1, 1'b1,
            mk_event(bkrd_pkg::EVT_DISCONNECT, 8'h00, 8'h00, 8'h00, 1'b0, 2'b00));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h00), 1'b1, 1'b1,
            mk_event(bkrd_pkg::EVT_KEY, 8'h00, 8'h00, 8'h00, 1'b0, 2'b00));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h00, 8'h04), 1'b1, 1'b1,
            mk_event(bkrd_pkg::EVT_KEY, 8'h00, 8'h04, "a", 1'b0, 2'b00));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h02, 8'h04));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h02));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h20, 8'h1e));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      bkrd_pkg::USAGE_CAPS_LOCK));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h00));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h00, 8'h04));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h22, 8'h04, 8'h05));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h00, bkrd_pkg::USAGE_NUM_LOCK,
                      bkrd_pkg::USAGE_CAPS_LOCK));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h00, bkrd_pkg::USAGE_NUM_LOCK));
    add_row(mk_report(8'd7, 8'h00, 8'h04), 1'b1, 1'b0);
    add_row(mk_report(8'hff, 8'hff, 8'h05), 1'b1, 1'b0);
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h00, 8'h04, bkrd_pkg::USAGE_ERR_LO), 1'b1, 1'b0);
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02),
            1'b1, 1'b0);
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      bkrd_pkg::USAGE_ERR_HI),
            1'b1, 1'b0);
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'hff, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h00, 8'h0b, 8'h0b));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'hff, 8'hff));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h00, 8'he7));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h00, 8'h58));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h00, 8'h85));
    add_row(mk_report(bkrd_pkg::LEN_DISCONNECT, 8'h00), 1'b1, 1'b1,
            mk_event(bkrd_pkg::EVT_DISCONNECT, 8'h00, 8'h00, 8'h00, 1'b0, 2'b00));
    add_row(mk_report(bkrd_pkg::REPORT_LEN, 8'h00, 8'h04), 1'b1, 1'b1,
            mk_event(bkrd_pkg::EVT_KEY, 8'h00, 8'h04, "a", 1'b0, 2'b00));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_q[i]) send_row(dir_q[i]);
    wait_drained();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_drained();
      send_row(random_row());
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && event_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
